// ===== rtl/core/gb3_pkg.sv =====
// Shared types and constants for the 3x3 Gaussian blur stream.
package gb3_pkg;

	localparam int SAMPLE_W   = 8;
	localparam int NUM_FIELDS = 4;
	localparam int COL_W      = 12;
	localparam int ROW_W      = 16;
	localparam int IMG_W_W    = 13;
	localparam int CHAN_W     = 3;
	localparam int CFG_DATA_W = 16;
	localparam int COLSUM_W   = SAMPLE_W + 2;
	localparam int WINSUM_W   = SAMPLE_W + 4;

	typedef logic [1:0] cfg_index_t;

	localparam cfg_index_t REG_IMAGE_WIDTH   = 2'd0;
	localparam cfg_index_t REG_IMAGE_HEIGHT  = 2'd1;
	localparam cfg_index_t REG_CHANNEL_COUNT = 2'd2;

	localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [ROW_W-1:0]   HEIGHT_RESET = 16'd480;
	localparam logic [CHAN_W-1:0]  CHAN_RESET   = 3'd3;

	// One channel of the 3x3 window, indexed [column][row], column 0 the oldest.
	typedef logic [2:0][2:0][SAMPLE_W-1:0] tap_win_t;

endpackage

// ===== rtl/core/gb3_if.sv =====
// Stream interfaces for incoming pixels and filtered results.
interface gb3_pix_if;
	import gb3_pkg::*;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_0;
	logic [SAMPLE_W-1:0] sample_1;
	logic [SAMPLE_W-1:0] sample_2;
	logic [SAMPLE_W-1:0] sample_3;
	modport source (output valid, output sample_0, output sample_1, output sample_2,
		output sample_3, input ready);
	modport sink (input valid, input sample_0, input sample_1, input sample_2,
		input sample_3, output ready);
endinterface

interface gb3_res_if;
	import gb3_pkg::*;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] blurred_0;
	logic [SAMPLE_W-1:0] blurred_1;
	logic [SAMPLE_W-1:0] blurred_2;
	logic [SAMPLE_W-1:0] blurred_3;
	logic [COL_W-1:0]    out_col;
	logic [ROW_W-1:0]    out_row;
	logic                frame_end;
	modport source (output valid, output blurred_0, output blurred_1, output blurred_2,
		output blurred_3, output out_col, output out_row, output frame_end, input ready);
	modport sink (input valid, input blurred_0, input blurred_1, input blurred_2,
		input blurred_3, input out_col, input out_row, input frame_end, output ready);
endinterface

// ===== rtl/core/gaussian_blur_3x3_stream_top.sv =====
// Top level of the streaming 3x3 Gaussian blur with one kernel lane per channel.
//
// Pixels enter on the pixel channel in raster order, one pixel of up to four 8-bit
// channels per transaction. A result leaves on the result channel for every interior
// pixel, carrying the blurred channels, the centre column and row, and a flag on the
// last interior pixel of the frame. Border pixels produce no result.
// The configuration port sets width, height and channel count; any write restarts the
// frame at row 0, column 0, and must only happen while the block is idle.
// A result passes the first-stage, column-sum and output registers after the pixel
// that completes its window. Throughput: one pixel per cycle while the receiver keeps
// up, set by the row memory's one read and one write port, each used once per pixel.
// When the receiver stalls, the output register holds its result and the two internal
// stages keep filling; pixel.ready drops only once both stages are occupied.
// Reset clears the counters, the window and all valid flags and restores 640x480 with
// three channels; the row memory is not cleared and needs no clearing pass.
module gaussian_blur_3x3_stream_top #(
	parameter int MAX_WIDTH    = 4096,
	parameter int MAX_CHANNELS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          write_en,
	input  gb3_pkg::cfg_index_t           reg_index,
	input  logic [gb3_pkg::CFG_DATA_W-1:0] write_data,
	gb3_pix_if.sink                       pixel,
	gb3_res_if.source                     result
);
	import gb3_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int PW = MAX_CHANNELS * SAMPLE_W;

	typedef logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] pix_t;

	typedef struct packed {
		logic             emit;
		logic             frame_end;
		logic [CW-1:0]    addr;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} ctl_t;

	logic [IMG_W_W-1:0] width_q;
	logic [ROW_W-1:0]   height_q;
	logic [CHAN_W-1:0]  chan_q;
	logic [WW-1:0]      weff;
	logic [ROW_W-1:0]   heff;
	logic [CHAN_W-1:0]  neff;

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic             last_col;
	logic             last_row;
	logic             accept;

	logic [NUM_FIELDS-1:0][SAMPLE_W-1:0] all_samples;
	pix_t px_in;
	ctl_t ctl_in;

	logic v1_q;
	logic v2_q;
	logic out_v_q;
	logic out_free;
	logic s2_free;
	logic adv1;
	logic adv2;

	pix_t px_s1;
	ctl_t ctl_s1;
	ctl_t ctl_s2;
	pix_t top_row;
	pix_t mid_row;
	pix_t win_q [6];

	logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] lane_blur;
	logic [NUM_FIELDS-1:0][SAMPLE_W-1:0]   blur_mux;
	logic [NUM_FIELDS-1:0][SAMPLE_W-1:0]   out_blur_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;
	logic             out_end_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			chan_q   <= CHAN_RESET;
		end else if (write_en) begin
			case (reg_index)
				REG_IMAGE_WIDTH:   width_q  <= write_data[IMG_W_W-1:0];
				REG_IMAGE_HEIGHT:  height_q <= write_data[ROW_W-1:0];
				REG_CHANNEL_COUNT: chan_q   <= write_data[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	// Out-of-range settings are clamped to the nearest usable value.
	always_comb begin
		if (width_q < 13'd3) begin
			weff = WW'(3);
		end else if (32'(width_q) > MAX_WIDTH) begin
			weff = WW'(MAX_WIDTH);
		end else begin
			weff = WW'(width_q);
		end
		heff = (height_q < 16'd3) ? 16'd3 : height_q;
		if (chan_q == 3'd0) begin
			neff = 3'd1;
		end else if (32'(chan_q) > MAX_CHANNELS) begin
			neff = CHAN_W'(MAX_CHANNELS);
		end else begin
			neff = chan_q;
		end
	end

	// Handshake: each stage moves on when the one after it is free or moving.
	assign out_free    = !out_v_q || result.ready;
	assign s2_free     = !v2_q || out_free;
	assign adv2        = v2_q && out_free;
	assign adv1        = v1_q && s2_free;
	assign pixel.ready = !v1_q || s2_free;
	assign accept      = pixel.valid && pixel.ready;

	assign all_samples = {pixel.sample_3, pixel.sample_2, pixel.sample_1, pixel.sample_0};
	assign px_in       = all_samples[MAX_CHANNELS-1:0];

	assign last_col = (col_q == CW'(weff - WW'(1)));
	assign last_row = (row_q == heff - 16'd1);

	always_comb begin
		ctl_in.emit      = (row_q >= 16'd2) && (col_q >= CW'(2));
		ctl_in.frame_end = last_col && last_row;
		ctl_in.addr      = col_q;
		ctl_in.col       = COL_W'(col_q - CW'(1));
		ctl_in.row       = row_q - 16'd1;
	end

	// Raster position of the next pixel; any configuration write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (write_en) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept) begin
				v1_q <= 1'b1;
			end else if (adv1) begin
				v1_q <= 1'b0;
			end
			if (adv1) begin
				v2_q <= ctl_s1.emit;
			end else if (adv2) begin
				v2_q <= 1'b0;
			end
			if (adv2) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1  <= px_in;
			ctl_s1 <= ctl_in;
		end
		if (adv1) begin
			ctl_s2 <= ctl_s1;
		end
	end

	// The read is issued with the transaction so the rows are ready in the first stage.
	gb3_line_store #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (PW)
	) u_line_store (
		.clk      (clk),
		.rd_en    (accept),
		.rd_addr  (col_q),
		.rd_above (mid_row),
		.rd_two   (top_row),
		.wr_en    (adv1),
		.wr_addr  (ctl_s1.addr),
		.wr_above (px_s1),
		.wr_two   (mid_row)
	);

	// Window columns: entries 0..2 hold column c-2, entries 3..5 column c-1, top first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (write_en) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_row;
			win_q[4] <= mid_row;
			win_q[5] <= px_s1;
		end
	end

	for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_lane
		tap_win_t taps;
		always_comb begin
			taps[0][0] = win_q[0][k];
			taps[0][1] = win_q[1][k];
			taps[0][2] = win_q[2][k];
			taps[1][0] = win_q[3][k];
			taps[1][1] = win_q[4][k];
			taps[1][2] = win_q[5][k];
			taps[2][0] = top_row[k];
			taps[2][1] = mid_row[k];
			taps[2][2] = px_s1[k];
		end
		gb3_lane u_lane (
			.clk  (clk),
			.load (adv1),
			.taps (taps),
			.blur (lane_blur[k])
		);
	end

	// Merge the lanes; channels beyond the configured count read as zero.
	for (genvar k = 0; k < NUM_FIELDS; k++) begin : g_merge
		if (k < MAX_CHANNELS) begin : g_used
			assign blur_mux[k] = (CHAN_W'(k) < neff) ? lane_blur[k] : '0;
		end else begin : g_unused
			assign blur_mux[k] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			out_blur_q <= blur_mux;
			out_col_q  <= ctl_s2.col;
			out_row_q  <= ctl_s2.row;
			out_end_q  <= ctl_s2.frame_end;
		end
	end

	assign result.valid     = out_v_q;
	assign result.blurred_0 = out_blur_q[0];
	assign result.blurred_1 = out_blur_q[1];
	assign result.blurred_2 = out_blur_q[2];
	assign result.blurred_3 = out_blur_q[3];
	assign result.out_col   = out_col_q;
	assign result.out_row   = out_row_q;
	assign result.frame_end = out_end_q;
endmodule

// ===== rtl/core/gb3_line_store.sv =====
// Row memory holding the two previous image rows, one entry per column.
module gb3_line_store #(
	parameter int DEPTH  = 4096,
	parameter int DATA_W = 32
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_above,
	output logic [DATA_W-1:0]        rd_two,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_above,
	input  logic [DATA_W-1:0]        wr_two
);
	// Each entry packs the row above in the upper half and the row two above in the lower.
	logic [2*DATA_W-1:0] rows_mem [DEPTH];
	logic [2*DATA_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rows_mem[wr_addr] <= {wr_above, wr_two};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= rows_mem[rd_addr];
		end
	end

	assign rd_above = rd_q[2*DATA_W-1:DATA_W];
	assign rd_two   = rd_q[DATA_W-1:0];
endmodule

// ===== rtl/core/gb3_lane.sv =====
// One channel of the 3x3 kernel: column sums registered, then the weighted total.
module gb3_lane (
	input  logic                      clk,
	input  logic                      load,
	input  gb3_pkg::tap_win_t         taps,
	output logic [gb3_pkg::SAMPLE_W-1:0] blur
);
	import gb3_pkg::*;

	logic [2:0][COLSUM_W-1:0] col_sum;
	logic [2:0][COLSUM_W-1:0] col_sum_s2;
	logic [WINSUM_W-1:0]      win_sum;

	// Vertical pass applies 1 2 1 to each column.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			col_sum[i] = {2'b00, taps[i][0]} + {1'b0, taps[i][1], 1'b0} + {2'b00, taps[i][2]};
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			col_sum_s2 <= col_sum;
		end
	end

	// Horizontal pass applies 1 2 1 across the columns; the total of weights is 16.
	assign win_sum = {2'b00, col_sum_s2[0]} + {1'b0, col_sum_s2[1], 1'b0}
		+ {2'b00, col_sum_s2[2]};
	assign blur = win_sum[WINSUM_W-1:4];
endmodule
